@@ rtl/atc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg: shared types and constants of the address tag cache
// Command codes, field widths and controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package atc_pkg;

	localparam int ENTRIES_DEF = 10;
	localparam int ADDR_W      = 64;
	localparam int HIT_INDEX_W = 4;

	typedef enum logic [1:0] {
		OP_INS_EXPORT  = 2'd0,
		OP_INS_UNKNOWN = 2'd1,
		OP_LOOKUP      = 2'd2,
		OP_INVALIDATE  = 2'd3
	} atc_op_t;

	typedef struct packed {
		logic load;  // capture request into stage 1
		logic exec;  // execute stage 1 item, load result register
	} atc_cmd_t;

endpackage

@@ rtl/atc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_req_if / atc_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface atc_req_if import atc_pkg::*; ();
	logic                valid;
	logic                ready;
	atc_op_t             cmd;
	logic [ADDR_W-1:0]   code_address;
	logic [ADDR_W-1:0]   range_base;
	logic [ADDR_W-1:0]   range_length;

	modport source (output valid, cmd, code_address, range_base, range_length, input ready);
	modport sink   (input valid, cmd, code_address, range_base, range_length, output ready);
endinterface

interface atc_rsp_if import atc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [HIT_INDEX_W-1:0] hit_index;
	logic                   is_export;
	logic                   is_unknown;

	modport source (output valid, hit, hit_index, is_export, is_unknown, input ready);
	modport sink   (input valid, hit, hit_index, is_export, is_unknown, output ready);
endinterface

@@ rtl/atc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_ctrl: transfer control of the address tag cache
// Tracks occupancy of the staging register and the result register.
// ----------------------------------------------------------------------------
module atc_ctrl import atc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output atc_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_STAGED,
		ST_DONE,
		ST_BOTH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   s1_valid;
	logic   s1_next;
	logic   out_next;

	always_comb begin
		unique case (state_q)
			ST_EMPTY:  begin s1_valid = 1'b0; rsp_valid = 1'b0; end
			ST_STAGED: begin s1_valid = 1'b1; rsp_valid = 1'b0; end
			ST_DONE:   begin s1_valid = 1'b0; rsp_valid = 1'b1; end
			ST_BOTH:   begin s1_valid = 1'b1; rsp_valid = 1'b1; end
			default:   begin s1_valid = 1'b0; rsp_valid = 1'b0; end
		endcase
	end

	always_comb begin
		cmd.exec  = s1_valid && (!rsp_valid || rsp_ready);
		req_ready = !s1_valid || cmd.exec;
		cmd.load  = req_valid && req_ready;
		s1_next   = cmd.load || (s1_valid && !cmd.exec);
		out_next  = cmd.exec || (rsp_valid && !rsp_ready);
		unique case ({s1_next, out_next})
			2'b00:   state_d = ST_EMPTY;
			2'b10:   state_d = ST_STAGED;
			2'b01:   state_d = ST_DONE;
			2'b11:   state_d = ST_BOTH;
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/atc_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_dpath: entry storage, comparators and result register
// Stage 1 holds the request and the range end; execution updates entries.
// ----------------------------------------------------------------------------
module atc_dpath import atc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  atc_cmd_t               cmd,
	input  atc_op_t                op,
	input  logic [ADDR_W-1:0]      code_address,
	input  logic [ADDR_W-1:0]      range_base,
	input  logic [ADDR_W-1:0]      range_length,
	output logic                   hit,
	output logic [HIT_INDEX_W-1:0] hit_index,
	output logic                   is_export,
	output logic                   is_unknown
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int PTR_W = $clog2(ENTRIES + 1);

	atc_op_t           op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] base_s1;
	logic [ADDR_W-1:0] end_s1;

	logic [ADDR_W-1:0] addr_q [ENTRIES];
	logic              exp_q  [ENTRIES];
	logic              unk_q  [ENTRIES];
	logic [PTR_W-1:0]  ptr_q;

	logic [ENTRIES-1:0] lk_match;
	logic [ENTRIES-1:0] iv_match;
	logic [IDX_W-1:0]   sel_idx;
	logic [PTR_W-1:0]   wp;
	logic               is_ins;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1   <= op;
			addr_s1 <= code_address;
			base_s1 <= range_base;
			end_s1  <= range_base + range_length;
		end
	end

	always_comb begin
		sel_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			lk_match[i] = (addr_q[i] == addr_s1);
			iv_match[i] = (addr_q[i] >= base_s1) && (addr_q[i] < end_s1);
			if (lk_match[i]) begin
				sel_idx = IDX_W'(i);
			end
		end
		wp     = (ptr_q >= PTR_W'(ENTRIES)) ? '0 : ptr_q;
		is_ins = (op_s1 == OP_INS_EXPORT) || (op_s1 == OP_INS_UNKNOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				addr_q[i] <= '0;
				exp_q[i]  <= 1'b0;
				unk_q[i]  <= 1'b0;
			end
			ptr_q <= '0;
		end else if (cmd.exec) begin
			if (is_ins) begin
				addr_q[wp[IDX_W-1:0]] <= addr_s1;
				exp_q[wp[IDX_W-1:0]]  <= (op_s1 == OP_INS_EXPORT);
				unk_q[wp[IDX_W-1:0]]  <= (op_s1 == OP_INS_UNKNOWN);
				ptr_q                 <= wp + PTR_W'(1);
			end else if (op_s1 == OP_INVALIDATE) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (iv_match[i]) begin
						addr_q[i] <= '0;
						exp_q[i]  <= 1'b0;
						unk_q[i]  <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_s1 == OP_LOOKUP && (|lk_match)) begin
				hit        <= 1'b1;
				hit_index  <= HIT_INDEX_W'(sel_idx);
				is_export  <= exp_q[sel_idx];
				is_unknown <= unk_q[sel_idx];
			end else begin
				hit        <= 1'b0;
				hit_index  <= '0;
				is_export  <= 1'b0;
				is_unknown <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/address_tag_cache_round_robin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_tag_cache_round_robin: round-robin fully associative address cache
// Insert, lookup and range invalidate over a small set of 64-bit addresses.
// ----------------------------------------------------------------------------
// Every request transfer yields exactly one response transfer; only lookups
// report a hit, inserts and invalidates answer with all fields zero. A request
// spends time in a staging register, where the range end is summed, and is
// then executed against the ENTRIES parallel comparators that update the
// entries and load the response register; the
// block sustains one request per cycle while the response side keeps up.
// No clearing pass: entries reset to address zero at once.
module address_tag_cache_round_robin import atc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	atc_req_if.sink    req,
	atc_rsp_if.source  rsp
);

	atc_cmd_t cmd;

	atc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	atc_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (req.cmd),
		.code_address (req.code_address),
		.range_base   (req.range_base),
		.range_length (req.range_length),
		.hit          (rsp.hit),
		.hit_index    (rsp.hit_index),
		.is_export    (rsp.is_export),
		.is_unknown   (rsp.is_unknown)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.hit_index == '0 && !rsp.is_export && !rsp.is_unknown)
		else $error("miss response carries nonzero fields");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.is_export, rsp.is_unknown}))
		else $error("entry with both flags set");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready && !req.ready |=> !req.ready || rsp.ready)
		else $error("request accepted while staging and result are blocked");

endmodule

@@ bench/address_tag_cache_round_robin_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_tag_cache_round_robin_tb: self-checking bench for the address cache
// A short directed table (reset contents, extremes, pointer wrap, zero-length
// and wrapping ranges, duplicate entries), then a random command mix biased
// toward resident addresses. Source gaps and sink stalls are drawn per
// transfer. Each response transfer is checked against an untimed cache model.
// ----------------------------------------------------------------------------
module address_tag_cache_round_robin_tb;
	import atc_pkg::*;

	localparam int                CLK_PERIOD  = 10;
	localparam int                N_ENTRIES   = ENTRIES_DEF;
	localparam int                N_DIRECTED  = 25;
	localparam int                N_RANDOM    = 950;
	localparam int                SEGMENT_LEN = 64;
	localparam int                DRAIN_TAIL  = 8;
	localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;

	typedef struct packed {
		logic                   hit;
		logic [HIT_INDEX_W-1:0] hit_index;
		logic                   is_export;
		logic                   is_unknown;
	} cache_rsp_t;

	typedef struct packed {
		atc_op_t           cmd;
		logic [ADDR_W-1:0] code_address;
		logic [ADDR_W-1:0] range_base;
		logic [ADDR_W-1:0] range_length;
	} cache_req_t;

	typedef struct packed {
		cache_req_t req;
		logic       known_rsp;
		cache_rsp_t rsp;
	} stim_row_t;

	localparam cache_rsp_t RSP_EMPTY       = '0;
	localparam cache_rsp_t RSP_SLOT0_CLEAR = '{1'b1, 4'd0, 1'b0, 1'b0};

	logic clk = 1'b0;
	logic arst_n;

	atc_req_if req_if ();
	atc_rsp_if rsp_if ();

	address_tag_cache_round_robin #(
		.ENTRIES (N_ENTRIES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	logic [ADDR_W-1:0] model_addr    [N_ENTRIES];
	logic              model_export  [N_ENTRIES];
	logic              model_unknown [N_ENTRIES];
	int unsigned       model_wr_ptr;

	cache_rsp_t predicted_rsp_q [$];
	int         mismatch_count = 0;
	bit         src_idle_on    = 1'b1;
	bit         sink_stall_on  = 1'b1;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{'{OP_LOOKUP,      64'h0,                  ADDR_MAX, ADDR_MAX}, 1'b1, RSP_SLOT0_CLEAR},
		'{'{OP_LOOKUP,      ADDR_MAX,               64'h0,    64'h0},    1'b1, RSP_EMPTY},
		'{'{OP_INVALIDATE,  ADDR_MAX,               64'h0,    64'h0},    1'b1, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  ADDR_MAX,               ADDR_MAX, ADDR_MAX}, 1'b1, RSP_EMPTY},
		'{'{OP_INS_UNKNOWN, 64'h1,                  64'h0,    64'h0},    1'b1, RSP_EMPTY},
		'{'{OP_LOOKUP,      ADDR_MAX,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'h1,                  64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'h0,                  64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  64'h8000_0000_0000_0000, 64'h0,   64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_UNKNOWN, 64'h5555_5555_5555_5555, 64'h0,   64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  64'hAAAA_AAAA_AAAA_AAAA, 64'h0,   64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_UNKNOWN, 64'h1000,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  64'h1008,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_UNKNOWN, 64'h1010,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  64'h1,                  64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0,   64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INS_EXPORT,  64'h2000,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'h2000,               64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'h1,                  64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INVALIDATE,  64'h0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20},     1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'hFFFF_FFFF_FFFF_FFFE, 64'h0,   64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INVALIDATE,  64'h0,                  64'h1000, 64'h10},   1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      64'h0,                  64'h0,    64'h0},    1'b0, RSP_EMPTY},
		'{'{OP_INVALIDATE,  64'h0,                  64'h0,    ADDR_MAX}, 1'b0, RSP_EMPTY},
		'{'{OP_LOOKUP,      ADDR_MAX,               64'h0,    64'h0},    1'b0, RSP_EMPTY}
	};

	function automatic cache_rsp_t apply_cache_command(input cache_req_t r);
		cache_rsp_t        rsp;
		logic [ADDR_W-1:0] range_end;
		rsp       = RSP_EMPTY;
		range_end = r.range_base + r.range_length;
		case (r.cmd) inside
			OP_INS_EXPORT, OP_INS_UNKNOWN: begin
				if (model_wr_ptr >= N_ENTRIES)
					model_wr_ptr = 0;
				model_addr[model_wr_ptr]    = r.code_address;
				model_export[model_wr_ptr]  = (r.cmd == OP_INS_EXPORT);
				model_unknown[model_wr_ptr] = (r.cmd == OP_INS_UNKNOWN);
				model_wr_ptr++;
			end
			OP_LOOKUP: begin
				// walk down so the lowest match wins
				for (int i = N_ENTRIES - 1; i >= 0; i--)
					if (model_addr[i] == r.code_address)
						rsp = '{1'b1, HIT_INDEX_W'(i), model_export[i], model_unknown[i]};
			end
			default: begin
				for (int i = 0; i < N_ENTRIES; i++)
					if (model_addr[i] >= r.range_base && model_addr[i] < range_end) begin
						model_addr[i]    = '0;
						model_export[i]  = 1'b0;
						model_unknown[i] = 1'b0;
					end
			end
		endcase
		return rsp;
	endfunction

	function automatic cache_req_t random_cache_request();
		cache_req_t  r;
		int unsigned pick;
		int unsigned slot;
		r.code_address = {$urandom, $urandom};
		r.range_base   = {$urandom, $urandom};
		r.range_length = {$urandom, $urandom};
		pick           = $urandom_range(0, 99);
		slot           = $urandom_range(0, N_ENTRIES - 1);
		if (pick < 36) begin
			r.cmd = pick[0] ? OP_INS_UNKNOWN : OP_INS_EXPORT;
			case ($urandom_range(0, 3))
				0: r.code_address = ADDR_W'($urandom_range(0, 31));
				1: r.code_address = model_addr[slot];
				default: ;
			endcase
		end else if (pick < 82) begin
			r.cmd = OP_LOOKUP;
			case ($urandom_range(0, 7))
				0: r.code_address = '0;
				1, 2: ;
				default: r.code_address = model_addr[slot];
			endcase
		end else begin
			r.cmd = OP_INVALIDATE;
			case ($urandom_range(0, 5))
				0: r.range_length = '0;
				1: begin
					// end of range may wrap past the top
					r.range_base   = ADDR_MAX - ADDR_W'($urandom_range(0, 15));
					r.range_length = ADDR_W'($urandom_range(1, 64));
				end
				2: ;
				default: begin
					r.range_base   = model_addr[slot] - ADDR_W'($urandom_range(0, 3));
					r.range_length = ADDR_W'($urandom_range(0, 8));
				end
			endcase
		end
		return r;
	endfunction

	task automatic send_request(input cache_req_t r, input logic known,
			input cache_rsp_t want);
		int unsigned gap;
		cache_rsp_t  predicted;
		gap = src_idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.cmd          <= r.cmd;
		req_if.code_address <= r.code_address;
		req_if.range_base   <= r.range_base;
		req_if.range_length <= r.range_length;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		predicted = apply_cache_command(r);
		predicted_rsp_q.push_back(known ? want : predicted);
	endtask

	initial begin : stimulus
		arst_n              <= 1'b0;
		req_if.valid        <= 1'b0;
		req_if.cmd          <= OP_INS_EXPORT;
		req_if.code_address <= '0;
		req_if.range_base   <= '0;
		req_if.range_length <= '0;
		for (int i = 0; i < N_ENTRIES; i++) begin
			model_addr[i]    = '0;
			model_export[i]  = 1'b0;
			model_unknown[i] = 1'b0;
		end
		model_wr_ptr = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].known_rsp, directed_rows[i].rsp);
		for (int n = 0; n < N_RANDOM; n++) begin
			// per stretch, choose at random whether each side has gaps
			if (n % SEGMENT_LEN == 0) begin
				src_idle_on   = 1'($urandom_range(0, 1));
				sink_stall_on = 1'($urandom_range(0, 1));
			end
			send_request(random_cache_request(), 1'b0, RSP_EMPTY);
		end
		req_if.valid <= 1'b0;
		while (predicted_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : response_sink
		int unsigned stall;
		cache_rsp_t  want;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_stall_on ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			if (predicted_rsp_q.size() == 0) begin
				$error("response transfer with no request outstanding");
				mismatch_count++;
			end else begin
				want = predicted_rsp_q.pop_front();
				if (rsp_if.hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
					mismatch_count++;
				end
				if (rsp_if.hit_index !== want.hit_index) begin
					$error("hit_index: expected %0d, actual %0d", want.hit_index,
						rsp_if.hit_index);
					mismatch_count++;
				end
				if (rsp_if.is_export !== want.is_export) begin
					$error("is_export: expected %0d, actual %0d", want.is_export,
						rsp_if.is_export);
					mismatch_count++;
				end
				if (rsp_if.is_unknown !== want.is_unknown) begin
					$error("is_unknown: expected %0d, actual %0d", want.is_unknown,
						rsp_if.is_unknown);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#(2_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule

@@ address_tag_cache_round_robin.f @@
rtl/atc_pkg.sv
rtl/atc_req_if.sv
rtl/atc_ctrl.sv
rtl/atc_dpath.sv
rtl/address_tag_cache_round_robin.sv
bench/address_tag_cache_round_robin_tb.sv
